### src/msu_pkg.sv
`timescale 1ns / 1ps
// shared constants and types for the masked signature scan unit
package msu_pkg;

    // defaults for the top-level parameters
    localparam int MAX_PATTERN_DEF  = 24;
    localparam int OFFSET_BITS_DEF  = 32;
    localparam int ADDRESS_BITS_DEF = 48;

    // pattern and mask registers hold this many bytes, the rest are wildcards
    localparam int REG_BYTES = 24;

    // configuration port
    localparam int APB_DATA_W = 64;
    localparam int APB_ADDR_W = 6;
    localparam int REG_IDX_W  = 3;
    localparam int REG_LSB    = 3;

    localparam int FIELD_LEN_W  = 5;
    localparam int BASE_W       = 48;
    localparam int DISP_W       = 32;
    localparam int DISP_BYTES   = 4;

    typedef enum logic [REG_IDX_W-1:0] {
        REG_PATTERN_LOW  = 3'd0,
        REG_PATTERN_MID  = 3'd1,
        REG_PATTERN_HIGH = 3'd2,
        REG_COMPARE_MASK = 3'd3,
        REG_PATTERN_LEN  = 3'd4,
        REG_DISP_POS     = 3'd5,
        REG_INSTR_LEN    = 3'd6,
        REG_BASE_ADDR    = 3'd7
    } msu_reg_t;

    // per-cycle control for the window cells
    typedef struct packed {
        logic shift;
        logic clear;
    } msu_cell_ctrl_t;

endpackage

### src/msu_in_if.sv
`timescale 1ns / 1ps
// image byte channel
interface msu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] image_byte;
    logic       is_last;

    modport source (output valid, output image_byte, output is_last, input ready);
    modport sink (input valid, input image_byte, input is_last, output ready);
endinterface

### src/msu_out_if.sv
`timescale 1ns / 1ps
// scan result channel
interface msu_out_if #(
    parameter int ADDRESS_BITS = msu_pkg::ADDRESS_BITS_DEF
);
    logic                    valid;
    logic                    ready;
    logic                    status;
    logic [ADDRESS_BITS-1:0] match_address;
    logic [ADDRESS_BITS-1:0] target_address;

    modport source (output valid, output status, output match_address,
                    output target_address, input ready);
    modport sink (input valid, input status, input match_address,
                  input target_address, output ready);
endinterface

### src/msu_cell.sv
`timescale 1ns / 1ps
// one window cell: holds a byte, compares the incoming byte, offers displacement bytes
module msu_cell #(
    parameter int IDX         = 0,
    parameter int MAX_PATTERN = msu_pkg::MAX_PATTERN_DEF
) (
    input  logic                                     clk,
    input  logic                                     rst_n,
    input  msu_pkg::msu_cell_ctrl_t                  ctrl,
    input  logic [7:0]                               byte_in,
    input  logic [$clog2(MAX_PATTERN+1)-1:0]         len,
    input  logic [msu_pkg::FIELD_LEN_W-1:0]          disp_pos,
    input  logic [msu_pkg::REG_BYTES-1:0][7:0]       pattern,
    input  logic [msu_pkg::REG_BYTES-1:0]            mask,
    output logic [7:0]                               byte_out,
    output logic                                     ok,
    output logic [msu_pkg::DISP_BYTES-1:0][7:0]      lane
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int IW    = LEN_W + 1;
    localparam int RB_IW = $clog2(msu_pkg::REG_BYTES);

    logic [7:0]    byte_reg;
    logic [7:0]    byte_next;
    logic          in_use;
    logic [IW-1:0] k;
    logic [IW-1:0] rel;
    logic [7:0]    pat_byte;
    logic          must_match;

    always_comb
    begin
        byte_next = byte_reg;
        if (ctrl.clear)
        begin
            byte_next = '0;
        end
        else if (ctrl.shift)
        begin
            byte_next = byte_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_reg <= '0;
        end
        else
        begin
            byte_reg <= byte_next;
        end
    end

    assign byte_out = byte_reg;

    // k is this cell's position in the match, oldest byte first
    always_comb
    begin
        in_use     = IW'(IDX) < IW'(len);
        k          = IW'(len) - IW'(IDX) - IW'(1);
        pat_byte   = '0;
        must_match = 1'b0;
        if (k < IW'(msu_pkg::REG_BYTES))
        begin
            pat_byte   = pattern[k[RB_IW-1:0]];
            must_match = mask[k[RB_IW-1:0]];
        end
        ok = !in_use || !must_match || (byte_in == pat_byte);
    end

    always_comb
    begin
        rel  = k - IW'(disp_pos);
        lane = '0;
        if (in_use && (k >= IW'(disp_pos)) && (rel < IW'(msu_pkg::DISP_BYTES)))
        begin
            lane[rel[1:0]] = byte_in;
        end
    end

endmodule

### src/msu_resolve.sv
`timescale 1ns / 1ps
// address resolution pipe: match address, then target address, then output register
module msu_resolve #(
    parameter int OFFSET_BITS  = msu_pkg::OFFSET_BITS_DEF,
    parameter int ADDRESS_BITS = msu_pkg::ADDRESS_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic                              in_status,
    input  logic [OFFSET_BITS-1:0]            in_off,
    input  logic [msu_pkg::DISP_W-1:0]        in_disp,
    input  logic [msu_pkg::FIELD_LEN_W-1:0]   in_ilen,
    input  logic [msu_pkg::BASE_W-1:0]        base,
    msu_out_if.source                         result
);

    logic                              s1_valid_reg;
    logic                              s1_status_reg;
    logic [OFFSET_BITS-1:0]            s1_off_reg;
    logic [msu_pkg::DISP_W-1:0]        s1_disp_reg;
    logic [msu_pkg::FIELD_LEN_W-1:0]   s1_ilen_reg;

    logic                              s2_valid_reg;
    logic                              s2_status_reg;
    logic [ADDRESS_BITS-1:0]           s2_maddr_reg;
    logic [ADDRESS_BITS-1:0]           s2_tsum_reg;

    logic                              s3_valid_reg;
    logic                              s3_status_reg;
    logic [ADDRESS_BITS-1:0]           s3_maddr_reg;
    logic [ADDRESS_BITS-1:0]           s3_taddr_reg;

    logic s1_ready;
    logic s2_ready;
    logic s3_ready;

    assign s3_ready = !s3_valid_reg || result.ready;
    assign s2_ready = !s2_valid_reg || s3_ready;
    assign s1_ready = !s1_valid_reg || s2_ready;
    assign in_ready = s1_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_ready)
            begin
                s1_valid_reg <= in_valid;
            end
            if (s2_ready)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s3_ready)
            begin
                s3_valid_reg <= s2_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_ready && in_valid)
        begin
            s1_status_reg <= in_status;
            s1_off_reg    <= in_off;
            s1_disp_reg   <= in_disp;
            s1_ilen_reg   <= in_ilen;
        end
        // displacement is instruction relative and signed
        if (s2_ready && s1_valid_reg)
        begin
            s2_status_reg <= s1_status_reg;
            s2_maddr_reg  <= ADDRESS_BITS'(base) + ADDRESS_BITS'(s1_off_reg);
            s2_tsum_reg   <= ADDRESS_BITS'(s1_ilen_reg)
                             + ADDRESS_BITS'($signed(s1_disp_reg));
        end
        if (s3_ready && s2_valid_reg)
        begin
            s3_status_reg <= s2_status_reg;
            s3_maddr_reg  <= s2_status_reg ? '0 : s2_maddr_reg;
            s3_taddr_reg  <= s2_status_reg ? '0 : (s2_maddr_reg + s2_tsum_reg);
        end
    end

    assign result.valid          = s3_valid_reg;
    assign result.status         = s3_status_reg;
    assign result.match_address  = s3_maddr_reg;
    assign result.target_address = s3_taddr_reg;

endmodule

### src/masked_signature_scan_unit.sv
`timescale 1ns / 1ps
// masked signature scan: register file, row of window cells, result pipe
// one image byte is taken every cycle while the result pipe is ready; the whole
//   window compare is done in the cycle the byte arrives, across the row of cells
// a result beat is offered through three pipe registers after the byte that causes it
//   is taken; each register takes a beat while later ones are stalled
// asynchronous active-low reset puts the registers at their reset values and
//   empties the window, the byte count and the result pipe; no clearing pass
module masked_signature_scan_unit #(
    parameter int MAX_PATTERN  = msu_pkg::MAX_PATTERN_DEF,
    parameter int OFFSET_BITS  = msu_pkg::OFFSET_BITS_DEF,
    parameter int ADDRESS_BITS = msu_pkg::ADDRESS_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    msu_in_if.sink                            image,
    msu_out_if.source                         result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [msu_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [msu_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [msu_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready
);

    localparam int LEN_W = $clog2(MAX_PATTERN + 1);
    localparam int CW    = (LEN_W > msu_pkg::FIELD_LEN_W) ? LEN_W : msu_pkg::FIELD_LEN_W;

    // configuration registers
    logic [63:0]                            pat_low_reg;
    logic [63:0]                            pat_mid_reg;
    logic [63:0]                            pat_high_reg;
    logic [msu_pkg::REG_BYTES-1:0]          mask_reg;
    logic [msu_pkg::FIELD_LEN_W-1:0]        plen_reg;
    logic [msu_pkg::FIELD_LEN_W-1:0]        dpos_reg;
    logic [msu_pkg::FIELD_LEN_W-1:0]        ilen_reg;
    logic [msu_pkg::BASE_W-1:0]             base_reg;

    logic                                   cfg_wr;
    msu_pkg::msu_reg_t                      cfg_sel;

    // scan state
    logic [OFFSET_BITS-1:0]                 offset_reg;
    logic [OFFSET_BITS-1:0]                 offset_next;
    logic                                   done_reg;
    logic                                   done_next;

    logic                                   accept;
    logic                                   scan;
    logic [OFFSET_BITS-1:0]                 count;
    logic                                   full;
    logic                                   hit;
    logic [LEN_W-1:0]                       len;
    logic [CW-1:0]                          plen_w;
    msu_pkg::msu_cell_ctrl_t                cell_ctrl;

    logic [msu_pkg::REG_BYTES-1:0][7:0]     pattern;
    logic [MAX_PATTERN-1:0][7:0]            win;
    logic [MAX_PATTERN-1:0]                 cell_ok;
    logic [MAX_PATTERN-1:0][msu_pkg::DISP_BYTES-1:0][7:0] lanes;
    logic [msu_pkg::DISP_BYTES-1:0][7:0]    disp_bytes;

    logic                                   res_valid;
    logic                                   pipe_ready;

    // configuration port
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign cfg_sel = msu_pkg::msu_reg_t'(paddr[msu_pkg::REG_LSB +: msu_pkg::REG_IDX_W]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pat_low_reg  <= '0;
            pat_mid_reg  <= '0;
            pat_high_reg <= '0;
            mask_reg     <= '0;
            plen_reg     <= msu_pkg::FIELD_LEN_W'(1);
            dpos_reg     <= '0;
            ilen_reg     <= msu_pkg::FIELD_LEN_W'(1);
            base_reg     <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                msu_pkg::REG_PATTERN_LOW:  pat_low_reg  <= pwdata;
                msu_pkg::REG_PATTERN_MID:  pat_mid_reg  <= pwdata;
                msu_pkg::REG_PATTERN_HIGH: pat_high_reg <= pwdata;
                msu_pkg::REG_COMPARE_MASK: mask_reg     <= pwdata[msu_pkg::REG_BYTES-1:0];
                msu_pkg::REG_PATTERN_LEN:  plen_reg     <= pwdata[msu_pkg::FIELD_LEN_W-1:0];
                msu_pkg::REG_DISP_POS:     dpos_reg     <= pwdata[msu_pkg::FIELD_LEN_W-1:0];
                msu_pkg::REG_INSTR_LEN:    ilen_reg     <= pwdata[msu_pkg::FIELD_LEN_W-1:0];
                msu_pkg::REG_BASE_ADDR:    base_reg     <= pwdata[msu_pkg::BASE_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            msu_pkg::REG_PATTERN_LOW:  prdata = pat_low_reg;
            msu_pkg::REG_PATTERN_MID:  prdata = pat_mid_reg;
            msu_pkg::REG_PATTERN_HIGH: prdata = pat_high_reg;
            msu_pkg::REG_COMPARE_MASK: prdata = msu_pkg::APB_DATA_W'(mask_reg);
            msu_pkg::REG_PATTERN_LEN:  prdata = msu_pkg::APB_DATA_W'(plen_reg);
            msu_pkg::REG_DISP_POS:     prdata = msu_pkg::APB_DATA_W'(dpos_reg);
            msu_pkg::REG_INSTR_LEN:    prdata = msu_pkg::APB_DATA_W'(ilen_reg);
            msu_pkg::REG_BASE_ADDR:    prdata = msu_pkg::APB_DATA_W'(base_reg);
        endcase
    end

    assign pattern = {pat_high_reg, pat_mid_reg, pat_low_reg};

    // window length in use, clamped to one..MAX_PATTERN
    always_comb
    begin
        plen_w = CW'(plen_reg);
        if (plen_w == '0)
        begin
            len = LEN_W'(1);
        end
        else if (plen_w > CW'(MAX_PATTERN))
        begin
            len = LEN_W'(MAX_PATTERN);
        end
        else
        begin
            len = LEN_W'(plen_w);
        end
    end

    // scan control
    assign image.ready = pipe_ready;
    assign accept      = image.valid && image.ready;
    assign scan        = accept && !done_reg;

    assign count = (offset_reg == '1) ? offset_reg : (offset_reg + OFFSET_BITS'(1));
    assign full  = count >= OFFSET_BITS'(len);
    assign hit   = full && (&cell_ok);

    assign cell_ctrl.shift = scan;
    assign cell_ctrl.clear = accept && image.is_last;

    always_comb
    begin
        offset_next = offset_reg;
        done_next   = done_reg;
        if (accept)
        begin
            if (image.is_last)
            begin
                offset_next = '0;
                done_next   = 1'b0;
            end
            else if (!done_reg)
            begin
                offset_next = count;
                done_next   = hit;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            offset_reg <= offset_next;
            done_reg   <= done_next;
        end
    end

    // row of window cells, newest byte in cell zero
    genvar j;
    generate
        for (j = 0; j < MAX_PATTERN; j++)
        begin : g_cell
            logic [7:0] cin;
            if (j == 0)
            begin : g_head
                assign cin = image.image_byte;
            end
            else
            begin : g_link
                assign cin = win[j-1];
            end

            msu_cell #(
                .IDX         (j),
                .MAX_PATTERN (MAX_PATTERN)
            ) u_cell (
                .clk      (clk),
                .rst_n    (rst_n),
                .ctrl     (cell_ctrl),
                .byte_in  (cin),
                .len      (len),
                .disp_pos (dpos_reg),
                .pattern  (pattern),
                .mask     (mask_reg),
                .byte_out (win[j]),
                .ok       (cell_ok[j]),
                .lane     (lanes[j])
            );
        end
    endgenerate

    always_comb
    begin
        disp_bytes = '0;
        for (int i = 0; i < MAX_PATTERN; i++)
        begin
            disp_bytes = disp_bytes | lanes[i];
        end
    end

    // found beat, or not-found beat on the last byte
    assign res_valid = scan && (hit || image.is_last);

    msu_resolve #(
        .OFFSET_BITS  (OFFSET_BITS),
        .ADDRESS_BITS (ADDRESS_BITS)
    ) u_resolve (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (res_valid),
        .in_ready  (pipe_ready),
        .in_status (!hit),
        .in_off    (count - OFFSET_BITS'(len)),
        .in_disp   (disp_bytes),
        .in_ilen   (ilen_reg),
        .base      (base_reg),
        .result    (result)
    );

    a_hit_ends_search: assert property (@(posedge clk) disable iff (!rst_n)
        (scan && hit && !image.is_last) |=> done_reg)
        else $error("match did not end the search");

    a_done_is_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && done_reg) |-> !res_valid)
        else $error("beat produced after the search ended");

    a_last_clears: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && image.is_last) |=> ((offset_reg == '0) && !done_reg))
        else $error("image state not cleared after last byte");

    a_not_found_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.status) |->
            ((result.match_address == '0) && (result.target_address == '0)))
        else $error("not-found beat carries an address");

endmodule

### bench/masked_signature_scan_checker.sv
`timescale 1ns / 1ps
// scoreboard for the masked signature scan unit: tracks register writes, predicts and compares results
module masked_signature_scan_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    msu_in_if                              image,
    msu_out_if                             result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic                           pready,
    input  logic [msu_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [msu_pkg::APB_DATA_W-1:0] pwdata,
    output int                             fail_count,
    output int                             outstanding,
    output int                             found_count,
    output int                             missed_count
);
    import msu_pkg::*;

    localparam int WINDOW = MAX_PATTERN_DEF;

    typedef struct packed {
        logic                        status;
        logic [ADDRESS_BITS_DEF-1:0] match_address;
        logic [ADDRESS_BITS_DEF-1:0] target_address;
    } scan_result_t;

    // window_q[0] holds the newest byte
    logic [7:0]                 window_q [WINDOW];
    logic [OFFSET_BITS_DEF-1:0] seen_bytes;
    logic                       hit_reported;

    logic [8*REG_BYTES-1:0]     pattern_image;
    logic [REG_BYTES-1:0]       mask_image;
    logic [FIELD_LEN_W-1:0]     pattern_len;
    logic [FIELD_LEN_W-1:0]     disp_pos;
    logic [FIELD_LEN_W-1:0]     instr_len;
    logic [BASE_W-1:0]          base_addr;

    scan_result_t               expected_results [$];

    function automatic void clear_image();
        int k;
        for (k = 0; k < WINDOW; k++)
            window_q[k] = 8'h00;
        seen_bytes   = '0;
        hit_reported = 1'b0;
    endfunction

    // byte q of the current window, oldest first; zero past the window
    function automatic logic [7:0] match_byte(input int unsigned q, input int unsigned len);
        if (q >= len)
            return 8'h00;
        return window_q[len - 1 - q];
    endfunction

    function automatic void scan_byte(input logic [7:0] value, input logic last);
        int unsigned                len;
        int unsigned                k;
        int unsigned                pos;
        logic [OFFSET_BITS_DEF-1:0] count;
        logic [DISP_W-1:0]          disp;
        logic                       hit;
        logic                       produced;
        scan_result_t               r;
        len = (pattern_len == 0) ? 1 : (pattern_len > WINDOW) ? WINDOW : pattern_len;
        if (hit_reported)
        begin
            if (last)
                clear_image();
            return;
        end
        for (k = WINDOW - 1; k > 0; k--)
            window_q[k] = window_q[k - 1];
        window_q[0] = value;
        // offset pins at its top value on very long images
        count      = (&seen_bytes) ? seen_bytes : seen_bytes + 1'b1;
        seen_bytes = count;
        produced   = 1'b0;
        if (count >= len)
        begin
            hit = 1'b1;
            for (k = 0; k < len; k++)
                if (mask_image[k] && match_byte(k, len) != pattern_image[8*k +: 8])
                    hit = 1'b0;
            if (hit)
            begin
                pos  = disp_pos;
                disp = {match_byte(pos + 3, len), match_byte(pos + 2, len),
                        match_byte(pos + 1, len), match_byte(pos, len)};
                r.status         = 1'b0;
                r.match_address  = base_addr + BASE_W'(count - len);
                r.target_address = r.match_address + BASE_W'(instr_len)
                                 + {{(BASE_W-DISP_W){disp[DISP_W-1]}}, disp};
                expected_results.push_back(r);
                hit_reported = 1'b1;
                produced     = 1'b1;
            end
        end
        if (last)
        begin
            if (!produced)
            begin
                r.status         = 1'b1;
                r.match_address  = '0;
                r.target_address = '0;
                expected_results.push_back(r);
            end
            clear_image();
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        scan_result_t got;
        scan_result_t want;
        if (!rst_n)
        begin
            clear_image();
            pattern_image = '0;
            mask_image    = '0;
            pattern_len   = 5'd1;
            disp_pos      = 5'd0;
            instr_len     = 5'd1;
            base_addr     = '0;
            expected_results.delete();
            fail_count   = 0;
            found_count  = 0;
            missed_count = 0;
            outstanding <= 0;
        end
        else
        begin
            if (result.valid && result.ready)
            begin
                got.status         = result.status;
                got.match_address  = result.match_address;
                got.target_address = result.target_address;
                if (got.status)
                    missed_count++;
                else
                    found_count++;
                if (expected_results.size() == 0)
                begin
                    $error("result beat with nothing pending: status %0d match %h target %h",
                           got.status, got.match_address, got.target_address);
                    fail_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        fail_count++;
                    end
                    if (got.match_address !== want.match_address)
                    begin
                        $error("match_address: expected %h, got %h",
                               want.match_address, got.match_address);
                        fail_count++;
                    end
                    if (got.target_address !== want.target_address)
                    begin
                        $error("target_address: expected %h, got %h",
                               want.target_address, got.target_address);
                        fail_count++;
                    end
                end
            end
            // a register change applies from the byte after the write
            if (image.valid && image.ready)
                scan_byte(image.image_byte, image.is_last);
            if (psel && penable && pwrite && pready)
            begin
                case (msu_reg_t'(paddr[REG_LSB +: REG_IDX_W]))
                    REG_PATTERN_LOW:  pattern_image[63:0]    = pwdata;
                    REG_PATTERN_MID:  pattern_image[127:64]  = pwdata;
                    REG_PATTERN_HIGH: pattern_image[191:128] = pwdata;
                    REG_COMPARE_MASK: mask_image             = pwdata[REG_BYTES-1:0];
                    REG_PATTERN_LEN:  pattern_len            = pwdata[FIELD_LEN_W-1:0];
                    REG_DISP_POS:     disp_pos               = pwdata[FIELD_LEN_W-1:0];
                    REG_INSTR_LEN:    instr_len              = pwdata[FIELD_LEN_W-1:0];
                    REG_BASE_ADDR:    base_addr              = pwdata[BASE_W-1:0];
                    default:          ;
                endcase
            end
            outstanding <= expected_results.size();
        end
    end

endmodule

### bench/masked_signature_scan_unit_test.sv
`timescale 1ns / 1ps
// top of the masked signature scan testbench: clock, reset, stimulus and verdict
module masked_signature_scan_unit_test;
    import msu_pkg::*;

    localparam int IDLE_PERCENT   = 14;
    localparam int HOLD_CYCLES    = 150;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int BYTE_BUDGET    = 1275;

    logic                  clk = 1'b0;
    logic                  rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    logic                  stall_enabled = 1'b1;
    logic                  hold_request  = 1'b0;
    bit                    idle_enabled  = 1'b1;

    int fail_count;
    int outstanding;
    int found_count;
    int missed_count;
    int bytes_sent       = 0;
    int images_sent      = 0;
    int settings_applied = 0;
    int quiet_cycles     = 0;

    // copy of the live settings, used to plant matching windows
    logic [8*REG_BYTES-1:0] pattern_image = '0;
    logic [REG_BYTES-1:0]   mask_image    = '0;
    int unsigned            window_len    = 1;
    logic [7:0]             image_bytes [$];

    msu_in_if  image_ch ();
    msu_out_if result_ch ();

    masked_signature_scan_unit u_top (
        .clk     (clk),
        .rst_n   (rst_n),
        .image   (image_ch),
        .result  (result_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    masked_signature_scan_checker u_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .image        (image_ch),
        .result       (result_ch),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .pready       (pready),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .fail_count   (fail_count),
        .outstanding  (outstanding),
        .found_count  (found_count),
        .missed_count (missed_count)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if ((image_ch.valid && image_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no beat moved for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    // result side: random back-pressure, plus one long hold-off on request
    initial
    begin
        result_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request    <= 1'b0;
                result_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                result_ch.ready <= rst_n
                                && !(stall_enabled && $urandom_range(99) < IDLE_PERCENT);
            end
        end
    end

    task automatic write_reg(input msu_reg_t idx, input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx) << REG_LSB;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_scan_config(input logic [63:0] pat_low, input logic [63:0] pat_mid,
                                   input logic [63:0] pat_high, input logic [63:0] mask_word,
                                   input logic [63:0] len_word, input logic [63:0] pos_word,
                                   input logic [63:0] instr_word, input logic [63:0] base_word);
        write_reg(REG_PATTERN_LOW, pat_low);
        write_reg(REG_PATTERN_MID, pat_mid);
        write_reg(REG_PATTERN_HIGH, pat_high);
        write_reg(REG_COMPARE_MASK, mask_word);
        write_reg(REG_PATTERN_LEN, len_word);
        write_reg(REG_DISP_POS, pos_word);
        write_reg(REG_INSTR_LEN, instr_word);
        write_reg(REG_BASE_ADDR, base_word);
        pattern_image = {pat_high, pat_mid, pat_low};
        mask_image    = mask_word[REG_BYTES-1:0];
        window_len    = (len_word[4:0] == 0) ? 1
                      : (len_word[4:0] > MAX_PATTERN_DEF) ? MAX_PATTERN_DEF : len_word[4:0];
        settings_applied++;
    endtask

    task automatic send_byte(input logic [7:0] value, input logic last);
        if (idle_enabled)
            while ($urandom_range(99) < IDLE_PERCENT)
            begin
                image_ch.valid <= 1'b0;
                @(posedge clk);
            end
        image_ch.valid      <= 1'b1;
        image_ch.image_byte <= value;
        image_ch.is_last    <= last;
        @(posedge clk);
        while (!image_ch.ready) @(posedge clk);
        bytes_sent++;
    endtask

    task automatic send_image();
        int unsigned k;
        for (k = 0; k < image_bytes.size(); k++)
            send_byte(image_bytes[k], k == image_bytes.size() - 1);
        image_bytes.delete();
        images_sent++;
    endtask

    // drop valid, drain every pending result, then let the pipe empty out
    task automatic wait_idle();
        image_ch.valid <= 1'b0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin
        int unsigned phase;
        int unsigned phase_stop;
        int unsigned raw_len;
        int unsigned len_eff;
        int unsigned raw_pos;
        int unsigned lead;
        int unsigned cut;
        int unsigned shape;
        int unsigned k;
        logic [63:0] mask_word;
        logic [63:0] base_word;

        image_ch.valid      <= 1'b0;
        image_ch.image_byte <= 8'h00;
        image_ch.is_last    <= 1'b0;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= '0;
        pwdata  <= '0;
        rst_n   <= 1'b0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: one-byte window, everything wildcard
        image_bytes.push_back(8'h00);
        send_image();
        image_bytes.push_back(8'hFF);
        send_image();
        wait_idle();

        // mov-style signature 8b 05 with a rip-relative displacement behind it
        set_scan_config(64'h0000_0000_0000_058B, {$urandom, $urandom}, {$urandom, $urandom},
                        64'h3, 64'd6, 64'd2, 64'd6, 64'h0000_0001_4000_0000);
        // match in the middle, bytes after it and the last byte give nothing
        image_bytes = '{8'h83, 8'h3D, 8'h8B, 8'h05, 8'hF8, 8'hFF, 8'hFF, 8'hFF, 8'h10, 8'h11};
        send_image();
        // image shorter than the window
        image_bytes = '{8'h8B, 8'h05, 8'h0D};
        send_image();
        // match on the last byte with the most negative displacement
        image_bytes = '{8'h8B, 8'h05, 8'h00, 8'h00, 8'h00, 8'h80};
        send_image();
        wait_idle();

        for (phase = 0; bytes_sent < BYTE_BUDGET; phase++)
        begin
            case (phase)
                0: set_scan_config('1, '1, '1, '1, '1, '1, '1, '1);
                1: set_scan_config('0, '0, '0, '0, '0, '0, '0, '0);
                2: set_scan_config({$urandom, $urandom}, {$urandom, $urandom},
                                   {$urandom, $urandom}, 64'hFF_FFFF, 64'd24, 64'd20, 64'd24,
                                   64'h0000_FFFF_FFFF_FFFF);
                default:
                begin
                    shape   = $urandom_range(9);
                    raw_len = (shape == 0) ? $urandom_range(25, 31)
                            : (shape == 1) ? 0
                            : (shape == 2) ? 24 : $urandom_range(1, 12);
                    len_eff = (raw_len == 0) ? 1 : (raw_len > 24) ? 24 : raw_len;
                    // mostly a displacement inside the window, sometimes past its end
                    if ($urandom_range(4) == 0 || len_eff < 4)
                        raw_pos = $urandom_range(0, 31);
                    else
                        raw_pos = $urandom_range(0, len_eff - 4);
                    case ($urandom_range(5))
                        0:       mask_word = 64'h0;
                        1:       mask_word = 64'hFF_FFFF;
                        default: mask_word = {$urandom, $urandom};
                    endcase
                    if ($urandom_range(3) != 0)
                        mask_word[63:REG_BYTES] = '0;
                    base_word = {$urandom, $urandom};
                    if ($urandom_range(3) == 0)
                        base_word = 64'h0000_FFFF_FFFF_F000 | $urandom_range(0, 4095);
                    set_scan_config({$urandom, $urandom}, {$urandom, $urandom},
                                    {$urandom, $urandom}, mask_word, 64'(raw_len),
                                    64'(raw_pos), 64'($urandom_range(0, 31)), base_word);
                end
            endcase

            // one phase runs flat out on both sides, one holds the result side off
            idle_enabled = (phase != 3);
            stall_enabled <= (phase != 3);
            if (phase == 4)
                hold_request <= 1'b1;
            phase_stop = bytes_sent + ((phase == 4) ? 40 : 90);

            while (bytes_sent < phase_stop)
            begin
                if (phase == 4)
                begin
                    // every one-byte image gives a result, so the pipe backs up
                    image_bytes.push_back(8'($urandom));
                end
                else
                begin
                    lead  = ($urandom_range(3) == 0) ? $urandom_range(0, 40)
                                                     : $urandom_range(0, 4);
                    shape = $urandom_range(9);
                    // whole planted window, a cut-off one, or noise only
                    cut   = (shape < 7) ? window_len
                          : (shape < 9) ? $urandom_range(0, window_len - 1) : 0;
                    repeat (lead) image_bytes.push_back(8'($urandom));
                    for (k = 0; k < cut; k++)
                        image_bytes.push_back(mask_image[k] ? pattern_image[8*k +: 8]
                                                            : 8'($urandom));
                    repeat ($urandom_range(0, 3)) image_bytes.push_back(8'($urandom));
                    if (image_bytes.size() == 0)
                        image_bytes.push_back(8'($urandom));
                end
                send_image();
            end
            wait_idle();
        end

        $display("covered %0d image bytes in %0d images across %0d register settings,",
                 bytes_sent, images_sent, settings_applied + 1);
        $display("  %0d signatures located and %0d images ended without a match",
                 found_count, missed_count);
        if (fail_count == 0 && outstanding == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
